// ===== rtl/core/gray_sobel_edge_threshold_defines.svh =====
// Assertion macros for the gray Sobel edge block.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef GRAY_SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define GRAY_SOBEL_EDGE_THRESHOLD_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define GSET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define GSET_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define GSET_ASSERT(label, prop, msg)
`define GSET_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/core/gset_pkg.sv =====
// Shared constants for the gray Sobel edge threshold block.
// Used by the top level, the checker and the testbench; no dependencies.
`timescale 1ns / 1ps

package gset_pkg;

    // Frame size limits used as parameter defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [PIX_W-1:0]   RST_EDGE_THRESHOLD = 8'd60;

    // Smallest frame side
    localparam int MIN_SIDE = 3;

    // Divide by three: (sum * 683) >> 11 is exact for sums up to 765
    localparam int SUM_W      = 10;
    localparam int GRAY_RECIP = 683;
    localparam int RECIP_W    = 10;
    localparam int GRAY_SHIFT = 11;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

endpackage

// ===== rtl/core/gray_sobel_edge_threshold.sv =====
// Channel | signals                             | direction | item
// --------+-------------------------------------+-----------+---------------------------------
// in      | in_valid in_ready red green blue    | input     | one RGB pixel, raster order
// out     | out_valid out_ready edge_value      | output    | one interior pixel result
//         | out_column out_row frame_last       |           |
// cfg     | cfg_valid cfg_ready cfg_index       | input     | one register write
//         | cfg_data                            |           |
//
// One pixel per clock sustained; the line buffer RAM takes one read and one write per cycle.
// A result passes the stage 1 registers, the window and stage 2 registers, then the result queue.
// A four-entry result queue keeps input flowing while the output is stalled; input stalls
// only once four accepted items are still unresolved.
// Reset clears counters, window and queue; the line buffer needs no clearing pass.
// Depends on gset_pkg, gset_ram and gray_sobel_edge_threshold_defines.svh.
`timescale 1ns / 1ps
`include "gray_sobel_edge_threshold_defines.svh"

module gray_sobel_edge_threshold #(
    parameter int MAX_WIDTH  = gset_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gset_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gset_pkg::PIX_W-1:0]      red,
    input  logic [gset_pkg::PIX_W-1:0]      green,
    input  logic [gset_pkg::PIX_W-1:0]      blue,
    // result output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gset_pkg::PIX_W-1:0]      edge_value,
    output logic [$clog2(MAX_WIDTH)-1:0]    out_column,
    output logic [$clog2(MAX_HEIGHT)-1:0]   out_row,
    output logic                            frame_last,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gset_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gset_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PW    = gset_pkg::PIX_W;
    localparam int SW    = gset_pkg::SUM_W;
    localparam int PRODW = gset_pkg::SUM_W + gset_pkg::RECIP_W;
    localparam int QD    = gset_pkg::FIFO_DEPTH;
    localparam int QPW   = gset_pkg::FIFO_PTR_W;
    localparam int QCW   = gset_pkg::FIFO_CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gset_pkg::IMG_W_W-1:0] image_width_reg;
    logic [gset_pkg::IMG_H_W-1:0] image_height_reg;
    logic [PW-1:0]                edge_threshold_reg;
    logic                         cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Take register writes; drop indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= gset_pkg::RST_IMAGE_WIDTH;
            image_height_reg   <= gset_pkg::RST_IMAGE_HEIGHT;
            edge_threshold_reg <= gset_pkg::RST_EDGE_THRESHOLD;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                gset_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[gset_pkg::IMG_W_W-1:0];
                gset_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[gset_pkg::IMG_H_W-1:0];
                gset_pkg::REG_EDGE_THRESHOLD:
                    edge_threshold_reg <= cfg_data[PW-1:0];
                default:
                    ;
            endcase
        end
    end

    // Saturate frame size and derive last column and last row
    logic [31:0]   w_sat;
    logic [31:0]   h_sat;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb
    begin
        if (32'(image_width_reg) < 32'(gset_pkg::MIN_SIDE))
            w_sat = 32'(gset_pkg::MIN_SIDE);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_sat = 32'(MAX_WIDTH);
        else
            w_sat = 32'(image_width_reg);

        if (32'(image_height_reg) < 32'(gset_pkg::MIN_SIDE))
            h_sat = 32'(gset_pkg::MIN_SIDE);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_sat = 32'(MAX_HEIGHT);
        else
            h_sat = 32'(image_height_reg);

        w_last = CW'(w_sat - 32'd1);
        h_last = RW'(h_sat - 32'd1);
    end

    // ------------------------------------------------------------------
    // Stage 0: accept pixel, issue line buffer read, step counters
    // ------------------------------------------------------------------
    logic [QCW-1:0] pend_reg;
    logic [QCW-1:0] pend_next;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic           in_fire;
    logic           col_at_end;
    logic           row_at_end;
    logic [SW-1:0]  rgb_sum;
    logic [PRODW-1:0] gray_prod;
    logic [PW-1:0]  gray;

    assign in_ready   = (pend_reg < QCW'(QD));
    assign in_fire    = in_valid & in_ready;
    assign col_at_end = (col_reg >= w_last);
    assign row_at_end = (row_reg >= h_last);

    // Gray as the sum divided by three through a reciprocal multiply
    assign rgb_sum   = SW'(red) + SW'(green) + SW'(blue);
    assign gray_prod = PRODW'(rgb_sum) * PRODW'(gset_pkg::GRAY_RECIP);
    assign gray      = gray_prod[gset_pkg::GRAY_SHIFT +: PW];

    // Wrap column at row end, row at frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (col_at_end)
            begin
                col_next = '0;
                row_next = row_at_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: pixel tag while the line buffer read completes
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [PW-1:0] s1_gray_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_has_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_ocol_reg;
    logic [RW-1:0] s1_orow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_gray_reg <= gray;
            s1_col_reg  <= col_reg;
            s1_has_reg  <= (col_reg >= CW'(2)) && (row_reg >= RW'(2));
            s1_last_reg <= col_at_end && row_at_end;
            s1_ocol_reg <= col_reg - CW'(1);
            s1_orow_reg <= row_reg - RW'(1);
        end
    end

    // Line buffer: each entry holds {older row, newer row} of one column.
    // Consecutive items always use different columns and a column comes back
    // only after at least three items, so a read never meets a pending write.
    logic [2*PW-1:0] lb_rd_data;
    logic [PW-1:0]   top_pix;
    logic [PW-1:0]   mid_pix;

    gset_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_pix, s1_gray_reg}),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data)
    );

    assign top_pix = lb_rd_data[2*PW-1:PW];
    assign mid_pix = lb_rd_data[PW-1:0];

    // ------------------------------------------------------------------
    // Window: advance one column per pixel, row-major, top row oldest
    // ------------------------------------------------------------------
    logic [PW-1:0] win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= top_pix;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid_pix;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Sobel x plus y, clamp and threshold
    // ------------------------------------------------------------------
    logic          s2_valid_reg;
    logic          s2_has_reg;
    logic          s2_last_reg;
    logic [CW-1:0] s2_ocol_reg;
    logic [RW-1:0] s2_orow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_has_reg  <= s1_has_reg;
            s2_last_reg <= s1_last_reg;
            s2_ocol_reg <= s1_ocol_reg;
            s2_orow_reg <= s1_orow_reg;
        end
    end

    // x plus y reduces to 2 * ((f + h + i) - (a + b + d))
    logic [SW-1:0]   pos_sum;
    logic [SW-1:0]   neg_sum;
    logic signed [SW:0] half_sum;
    logic [PW-1:0]   clamped;
    logic [PW-1:0]   edge_res;
    logic            push;
    logic            drop;

    assign pos_sum  = SW'(win_reg[5]) + SW'(win_reg[7]) + SW'(win_reg[8]);
    assign neg_sum  = SW'(win_reg[0]) + SW'(win_reg[1]) + SW'(win_reg[3]);
    assign half_sum = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});

    always_comb
    begin
        if (half_sum[SW])
            clamped = '0;
        else if (half_sum[SW-1:PW-1] != '0)
            clamped = gset_pkg::PIX_MAX;
        else
            clamped = {half_sum[PW-2:0], 1'b0};

        edge_res = (clamped > edge_threshold_reg) ? clamped : '0;
    end

    assign push = s2_valid_reg & s2_has_reg;
    assign drop = s2_valid_reg & ~s2_has_reg;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [PW-1:0]  q_val_reg  [QD];
    logic [CW-1:0]  q_col_reg  [QD];
    logic [RW-1:0]  q_row_reg  [QD];
    logic           q_last_reg [QD];
    logic [QPW-1:0] q_wr_ptr_reg;
    logic [QPW-1:0] q_rd_ptr_reg;
    logic [QCW-1:0] q_cnt_reg;
    logic           pop;

    assign out_valid  = (q_cnt_reg != '0);
    assign pop        = out_valid & out_ready;
    assign edge_value = q_val_reg[q_rd_ptr_reg];
    assign out_column = q_col_reg[q_rd_ptr_reg];
    assign out_row    = q_row_reg[q_rd_ptr_reg];
    assign frame_last = q_last_reg[q_rd_ptr_reg];

    // Store results at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_val_reg[q_wr_ptr_reg]  <= edge_res;
            q_col_reg[q_wr_ptr_reg]  <= s2_ocol_reg;
            q_row_reg[q_wr_ptr_reg]  <= s2_orow_reg;
            q_last_reg[q_wr_ptr_reg] <= s2_last_reg;
        end
    end

    // Items in flight or queued: add on accept, drop on pop or no result
    assign pend_next = pend_reg + QCW'(in_fire) - QCW'(pop) - QCW'(drop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_cnt_reg    <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (push)
                q_wr_ptr_reg <= q_wr_ptr_reg + QPW'(1);
            if (pop)
                q_rd_ptr_reg <= q_rd_ptr_reg + QPW'(1);
            q_cnt_reg <= q_cnt_reg + QCW'(push) - QCW'(pop);
            pend_reg  <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GSET_ASSERT(a_pend_bound, pend_reg <= QCW'(QD), "pending item count above queue depth")
    `GSET_ASSERT(a_queue_within_pend, q_cnt_reg <= pend_reg, "queue holds more than pending")
    `GSET_NEVER(a_push_full, push && (q_cnt_reg == QCW'(QD)), "result pushed into full queue")
    `GSET_NEVER(a_lb_collide, in_fire && s1_valid_reg && (s1_col_reg == col_reg),
                "line buffer read and write hit the same column")
    `GSET_ASSERT(a_read_to_write, in_fire |=> s1_valid_reg, "line buffer read without write back")

endmodule

// ===== rtl/core/gset_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gset_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/sv/gray_sobel_edge_checker.sv =====
`timescale 1ns / 1ps
// Checker for gray_sobel_edge_threshold: it follows the pixel, result and register
// write channels, predicts each interior pixel result and compares it field by field.
// Depends on gset_pkg for widths, register indexes and reset values.

module gray_sobel_edge_checker #(
    parameter int MAX_WIDTH  = gset_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gset_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [gset_pkg::PIX_W-1:0]      red,
    input  logic [gset_pkg::PIX_W-1:0]      green,
    input  logic [gset_pkg::PIX_W-1:0]      blue,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [gset_pkg::PIX_W-1:0]      edge_value,
    input  logic [$clog2(MAX_WIDTH)-1:0]    out_column,
    input  logic [$clog2(MAX_HEIGHT)-1:0]   out_row,
    input  logic                            frame_last,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gset_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gset_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              pending
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PX_W  = gset_pkg::PIX_W;

    typedef struct packed {
        logic [PX_W-1:0]  value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } edge_result_t;

    // Register copies
    logic [gset_pkg::IMG_W_W-1:0] width_reg;
    logic [gset_pkg::IMG_H_W-1:0] height_reg;
    logic [PX_W-1:0]              threshold_reg;

    // Gray history: two rows, the 3x3 window (row-major, top row oldest), position
    logic [PX_W-1:0]    older_row [MAX_WIDTH];
    logic [PX_W-1:0]    newer_row [MAX_WIDTH];
    logic [PX_W-1:0]    win [9];
    logic [COL_W-1:0]   next_col;
    logic [ROW_W-1:0]   next_row;

    edge_result_t       expected_edges [$];
    int                 error_count;

    // Saturate a frame side to the range the block supports
    function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
        if (v < gset_pkg::MIN_SIDE)
            return gset_pkg::MIN_SIDE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $error("%s expected %0d got %0d", field, want, got);
        end
    endtask

    // Take in one pixel: gray it, slide the window, emit for an interior pixel
    task automatic advance_pixel(input logic [PX_W-1:0] r, input logic [PX_W-1:0] g,
                                 input logic [PX_W-1:0] b);
        int unsigned      w, h, c, rw;
        logic [PX_W-1:0]  gray, above, middle;
        int               tap [9];
        int               sx, sy, level;
        edge_result_t     res;
        w = clamp_side(width_reg, MAX_WIDTH);
        h = clamp_side(height_reg, MAX_HEIGHT);
        c = next_col;
        rw = next_row;
        // average of the three components, rounded down
        gray = PX_W'((int'(r) + int'(g) + int'(b)) / 3);
        above = older_row[c];
        middle = newer_row[c];

        // shift the window left and insert the new column
        for (int i = 0; i < 9; i += 3)
        begin
            win[i] = win[i + 1];
            win[i + 1] = win[i + 2];
        end
        win[2] = above;
        win[5] = middle;
        win[8] = gray;
        older_row[c] = middle;
        newer_row[c] = gray;

        // horizontal plus vertical kernel sums, clamped, then thresholded
        if (c >= 2 && rw >= 2)
        begin
            for (int i = 0; i < 9; i++)
                tap[i] = int'(win[i]);
            sx = (tap[2] - tap[0]) + 2 * (tap[5] - tap[3]) + (tap[8] - tap[6]);
            sy = (tap[6] + 2 * tap[7] + tap[8]) - (tap[0] + 2 * tap[1] + tap[2]);
            level = sx + sy;
            if (level < 0)
                level = 0;
            if (level > int'(gset_pkg::PIX_MAX))
                level = int'(gset_pkg::PIX_MAX);
            if (level <= int'(threshold_reg))
                level = 0;
            res.value = PX_W'(level);
            res.column = COL_W'(c - 1);
            res.row = ROW_W'(rw - 1);
            res.last = (c >= w - 1) && (rw >= h - 1);
            expected_edges.push_back(res);
        end

        // advance the raster position; wrap at row and frame end
        if (c >= w - 1)
        begin
            next_col = '0;
            next_row = (rw >= h - 1) ? '0 : ROW_W'(rw + 1);
        end
        else
        begin
            next_col = COL_W'(c + 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : observe
        edge_result_t seen, want;
        if (!rst_n)
        begin
            width_reg = gset_pkg::RST_IMAGE_WIDTH;
            height_reg = gset_pkg::RST_IMAGE_HEIGHT;
            threshold_reg = gset_pkg::RST_EDGE_THRESHOLD;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            next_col = '0;
            next_row = '0;
            expected_edges.delete();
            error_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // compare a delivered result with the oldest prediction
            if (out_valid && out_ready)
            begin
                seen = {edge_value, out_column, out_row, frame_last};
                if (expected_edges.size() == 0)
                begin
                    error_count++;
                    $error("result at column %0d row %0d with nothing expected",
                           out_column, out_row);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    check_field("edge_value", want.value, seen.value);
                    check_field("out_column", want.column, seen.column);
                    check_field("out_row", want.row, seen.row);
                    check_field("frame_last", want.last, seen.last);
                end
            end

            // a pixel taken at this edge still sees the old register values
            if (in_valid && in_ready)
                advance_pixel(red, green, blue);

            // apply a register write; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gset_pkg::REG_IMAGE_WIDTH:
                        width_reg = cfg_data[gset_pkg::IMG_W_W-1:0];
                    gset_pkg::REG_IMAGE_HEIGHT:
                        height_reg = cfg_data[gset_pkg::IMG_H_W-1:0];
                    gset_pkg::REG_EDGE_THRESHOLD:
                        threshold_reg = cfg_data[PX_W-1:0];
                    default: ;
                endcase
            end

            mismatches <= error_count;
            pending <= expected_edges.size();
        end
    end

endmodule

// ===== tb/sv/tb_gray_sobel_edge_threshold.sv =====
`timescale 1ns / 1ps
// Top of the gray_sobel_edge_threshold testbench: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict.
// Depends on gset_pkg, the block and gray_sobel_edge_checker.

module tb_gray_sobel_edge_threshold;

    localparam int PX_W            = gset_pkg::PIX_W;
    localparam int IDX_W           = gset_pkg::CFG_IDX_W;
    localparam int DATA_W          = gset_pkg::CFG_W;
    localparam int SIDE_MIN        = gset_pkg::MIN_SIDE;
    localparam int COL_W           = $clog2(gset_pkg::DEF_MAX_WIDTH);
    localparam int ROW_W           = $clog2(gset_pkg::DEF_MAX_HEIGHT);
    localparam int CLK_HALF        = 4;
    localparam int IDLE_PCT        = 27;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 720;
    // Longest legal silence is the result hold-off; the limit lies well above it
    localparam int QUIET_LIMIT     = 2000;
    // Index past the register list; writes to it must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {TEX_NOISE, TEX_SOFT, TEX_EXTREMES} texture_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [PX_W-1:0]       red;
    logic [PX_W-1:0]       green;
    logic [PX_W-1:0]       blue;
    logic                  out_valid;
    logic                  out_ready;
    logic [PX_W-1:0]       edge_value;
    logic [COL_W-1:0]      out_column;
    logic [ROW_W-1:0]      out_row;
    logic                  frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [DATA_W-1:0]     cfg_data;
    int                    mismatches;
    int                    pending;
    bit                    no_idle;
    bit                    hold_off_request;

    gray_sobel_edge_threshold dut (.*);

    gray_sobel_edge_checker edge_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Offer one pixel after a random gap, hold it until taken
    task automatic push_pixel(input logic [PX_W-1:0] r, input logic [PX_W-1:0] g,
                              input logic [PX_W-1:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a register value for a side: sometimes one that saturates to it
    function automatic int side_code(input int eff, input int max_side, input int field_bits);
        if (eff == SIDE_MIN && $urandom_range(1))
            return $urandom_range(0, SIDE_MIN);
        if (eff == max_side && $urandom_range(1))
            return $urandom_range(max_side, (1 << field_bits) - 1);
        return eff;
    endfunction

    // Unused upper data bits carry noise
    task automatic set_geometry(input int w, input int h);
        logic [DATA_W-1:0] word;
        word = DATA_W'($urandom);
        word[gset_pkg::IMG_W_W-1:0] = gset_pkg::IMG_W_W'(
            side_code(w, gset_pkg::DEF_MAX_WIDTH, gset_pkg::IMG_W_W));
        write_reg(gset_pkg::REG_IMAGE_WIDTH, word);
        write_reg(gset_pkg::REG_IMAGE_HEIGHT,
                  DATA_W'(side_code(h, gset_pkg::DEF_MAX_HEIGHT, gset_pkg::IMG_H_W)));
    endtask

    task automatic set_threshold(input int thr);
        logic [DATA_W-1:0] word;
        word = DATA_W'($urandom);
        word[PX_W-1:0] = PX_W'(thr);
        write_reg(gset_pkg::REG_EDGE_THRESHOLD, word);
    endtask

    // Drop valid, then hold until every predicted result is out and the pipe is empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input int w, input int h, input texture_t tex);
        logic [PX_W-1:0] base;
        base = PX_W'($urandom_range(0, 252));
        repeat (w * h)
        begin
            case (tex)
                TEX_SOFT:
                    push_pixel(base + PX_W'($urandom_range(0, 3)),
                               base + PX_W'($urandom_range(0, 3)),
                               base + PX_W'($urandom_range(0, 3)));
                TEX_EXTREMES:
                    push_pixel($urandom_range(1) ? gset_pkg::PIX_MAX : '0,
                               $urandom_range(1) ? gset_pkg::PIX_MAX : '0,
                               $urandom_range(1) ? gset_pkg::PIX_MAX : '0);
                default:
                    push_pixel(PX_W'($urandom), PX_W'($urandom), PX_W'($urandom));
            endcase
        end
    endtask

    // One 3x3 frame with uniform rows
    task automatic send_rows(input logic [3*PX_W-1:0] top_px, input logic [3*PX_W-1:0] mid_px,
                             input logic [3*PX_W-1:0] bot_px);
        repeat (3) push_pixel(top_px[23:16], top_px[15:8], top_px[7:0]);
        repeat (3) push_pixel(mid_px[23:16], mid_px[15:8], mid_px[7:0]);
        repeat (3) push_pixel(bot_px[23:16], bot_px[15:8], bot_px[7:0]);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // End the run after too long without any item moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int       w, h, thr, frames, phase, random_sent;
        texture_t tex;
        in_valid <= 1'b0;
        red <= '0;
        green <= '0;
        blue <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= gset_pkg::REG_IMAGE_WIDTH;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset geometry: one full row and three pixels, no result yet
        repeat (int'(gset_pkg::RST_IMAGE_WIDTH) + 3)
            push_pixel(PX_W'($urandom), PX_W'($urandom), PX_W'($urandom));
        wait_drained();

        // Shrink to 3x3 in mid-frame: the next pixel closes the row, three more close
        // the frame with one interior result under the reset threshold
        set_geometry(SIDE_MIN, SIDE_MIN);
        repeat (4)
            push_pixel(PX_W'($urandom), PX_W'($urandom), PX_W'($urandom));
        wait_drained();
        set_threshold(0);

        // Directed frames: clamp high, clamp low with rounding, sum equal to threshold
        write_reg(REG_SPARE, DATA_W'($urandom));
        send_rows(24'h000000, 24'hFF0000, 24'hFFFFFF);
        send_rows(24'hFFFFFE, 24'h070809, 24'h000101);
        wait_drained();
        set_threshold(4);
        send_rows(24'h000000, 24'hC86400, 24'h000102);
        wait_drained();

        // Random phases of whole frames, mostly small
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS || phase < 3)
        begin
            w = ($urandom_range(9) < 8) ? $urandom_range(3, 12) : $urandom_range(13, 64);
            h = ($urandom_range(9) < 8) ? $urandom_range(3, 8) : $urandom_range(9, 24);
            case ($urandom_range(9))
                0:       thr = 0;
                1:       thr = 255;
                2, 3:    thr = $urandom_range(0, 8);
                default: thr = $urandom_range(0, 255);
            endcase
            tex = texture_t'($urandom_range(2));
            frames = $urandom_range(1, 3);
            if (phase == 2)
            begin
                w = 8;
                h = 8;
                frames = 2;
            end
            no_idle = (phase == 1);
            if ($urandom_range(1))
            begin
                set_threshold(thr);
                set_geometry(w, h);
            end
            else
            begin
                set_geometry(w, h);
                set_threshold(thr);
            end
            if ($urandom_range(7) == 0)
                write_reg(REG_SPARE, DATA_W'($urandom));
            // stall results long enough to back up the input
            if (phase == 2)
                hold_off_request = 1'b1;
            repeat (frames) send_frame(w, h, tex);
            random_sent += w * h * frames;
            wait_drained();
            no_idle = 1'b0;
            phase++;
        end

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
